@@ design/ddsr_pkg.sv @@
// ----------------------------------------------------------------------------
// ddsr_pkg
// Shared types and constants for the differential-drive speed ramp.
// ----------------------------------------------------------------------------
`default_nettype none

package ddsr_pkg;

  // Command codes carried by the opcode field
  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_FORWARD    = 3'd1,
    OP_REVERSE    = 3'd2,
    OP_TURN_RIGHT = 3'd3,
    OP_TURN_LEFT  = 3'd4,
    OP_STOP       = 3'd5,
    OP_SET_LEFT   = 3'd6,
    OP_SET_RIGHT  = 3'd7
  } op_e;

  // Configuration register map
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_DUTY   = 2'd0,
    CFG_DECEL_STEP = 2'd1
  } cfg_idx_e;

  localparam int unsigned MAX_DUTY_W = 10;
  localparam int unsigned DECEL_W    = 8;

  localparam logic [MAX_DUTY_W-1:0] MAX_DUTY_RST = 10'd626;
  localparam logic [DECEL_W-1:0]    DECEL_RST    = 8'd25;

endpackage : ddsr_pkg

`default_nettype wire

@@ design/ddsr_if.sv @@
// ----------------------------------------------------------------------------
// ddsr_if
// Valid/ready channel interfaces: command in, result out, config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddsr_cmd_if #(
  parameter int unsigned SPEED_WIDTH = 10
);
  logic                   valid;
  logic                   ready;
  ddsr_pkg::op_e          opcode;
  logic [SPEED_WIDTH-1:0] speed_arg;

  modport source (output valid, output opcode, output speed_arg, input ready);
  modport sink   (input valid, input opcode, input speed_arg, output ready);
endinterface : ddsr_cmd_if

interface ddsr_res_if #(
  parameter int unsigned SPEED_WIDTH = 10
);
  logic                   valid;
  logic                   ready;
  logic [SPEED_WIDTH-1:0] ch1_left_reverse;
  logic [SPEED_WIDTH-1:0] ch2_left_forward;
  logic [SPEED_WIDTH-1:0] ch3_right_forward;
  logic [SPEED_WIDTH-1:0] ch4_right_reverse;
  logic [SPEED_WIDTH-1:0] left_speed;
  logic [SPEED_WIDTH-1:0] right_speed;
  logic                   stopped;

  modport source (
    output valid, output ch1_left_reverse, output ch2_left_forward,
    output ch3_right_forward, output ch4_right_reverse,
    output left_speed, output right_speed, output stopped, input ready
  );
  modport sink (
    input valid, input ch1_left_reverse, input ch2_left_forward,
    input ch3_right_forward, input ch4_right_reverse,
    input left_speed, input right_speed, input stopped, output ready
  );
endinterface : ddsr_res_if

interface ddsr_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ddsr_pkg::CFG_IDX_W-1:0]     reg_index;
  logic [ddsr_pkg::CFG_DATA_W-1:0]    wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface : ddsr_cfg_if

`default_nettype wire

@@ design/ddsr_ramp.sv @@
// ----------------------------------------------------------------------------
// ddsr_ramp
// One tick of the speed ramp for one wheel: up by 1, down by the step (by 1 if the step exceeds the speed).
// ----------------------------------------------------------------------------
`default_nettype none

module ddsr_ramp #(
  parameter int unsigned SPEED_WIDTH = 10
) (
  input  logic [SPEED_WIDTH-1:0]           cur_i,
  input  logic [SPEED_WIDTH-1:0]           tgt_i,
  input  logic [ddsr_pkg::DECEL_W-1:0]     decel_i,
  output logic [SPEED_WIDTH-1:0]           next_o
);

  logic [SPEED_WIDTH-1:0] step;

  assign step = SPEED_WIDTH'(decel_i);

  always_comb begin
    priority if (cur_i < tgt_i) begin
      next_o = cur_i + SPEED_WIDTH'(1);
    end else if (cur_i > tgt_i) begin
      // large step would underflow: fall back to a unit step
      next_o = (cur_i >= step) ? (cur_i - step) : (cur_i - SPEED_WIDTH'(1));
    end else begin
      next_o = cur_i;
    end
  end

endmodule : ddsr_ramp

`default_nettype wire

@@ design/diff_drive_speed_ramp.sv @@
// ----------------------------------------------------------------------------
// diff_drive_speed_ramp
// Two-wheel PWM speed ramp with forward/reverse compare channel routing.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i  - command items (opcode, speed_arg). Forward, reverse, turns, stop
//            and set-target commands update targets and mode flags; a tick
//            ramps both wheel speeds one step and routes them to the compare
//            channels (2/3 forward, 1/4 reverse).
//   res_o  - one result item per command: four compare values, both current
//            speeds and the stopped flag, as seen after the command.
//   cfg_i  - register writes (0: max_duty, 1: decel_step); always ready.
//            Unknown indexes are dropped. Write only while idle.
// Timing:
//   The state update is one short combinational pass (clamp, two ramp units,
//   routing) from the state registers straight back into the state and result
//   registers, so one item is taken every cycle unless a held result stalls cmd_i.
// Reset:
//   Speeds, targets, modes and compare values clear; max_duty = 626,
//   decel_step = 25; no result is pending.
// Stall:
//   The result register holds while res_o.ready is low; cmd_i.ready drops
//   until that result is taken (it stays high while the result drains).
// ----------------------------------------------------------------------------
`default_nettype none

module diff_drive_speed_ramp #(
  parameter int unsigned SPEED_WIDTH = 10
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ddsr_cmd_if.sink   cmd_i,
  ddsr_res_if.source res_o,
  ddsr_cfg_if.sink   cfg_i
);

  typedef logic [SPEED_WIDTH-1:0] speed_t;

  // configuration
  logic [ddsr_pkg::MAX_DUTY_W-1:0] max_duty_q;
  logic [ddsr_pkg::DECEL_W-1:0]    decel_q;

  // motion state
  speed_t left_cur_q,  left_cur_d;
  speed_t right_cur_q, right_cur_d;
  speed_t left_tgt_q,  left_tgt_d;
  speed_t right_tgt_q, right_tgt_d;
  logic   fwd_q, fwd_d;
  logic   rev_q, rev_d;
  logic   turn_r_q, turn_r_d;
  logic   turn_l_q, turn_l_d;
  speed_t cmp_q [4];
  speed_t cmp_d [4];

  // result register
  logic   res_valid_q;
  logic   stopped_d, stopped_q;

  logic   cmd_fire;
  speed_t max_s, arg_s, s_clamped;
  speed_t left_ramp, right_ramp;

  // --------------------------------------------------------------------------
  // Config port
  // --------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_duty_q <= ddsr_pkg::MAX_DUTY_RST;
      decel_q    <= ddsr_pkg::DECEL_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.reg_index == ddsr_pkg::CFG_MAX_DUTY) begin
        max_duty_q <= ddsr_pkg::MAX_DUTY_W'(cfg_i.wdata);
      end else if (cfg_i.reg_index == ddsr_pkg::CFG_DECEL_STEP) begin
        decel_q <= ddsr_pkg::DECEL_W'(cfg_i.wdata);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: take a command whenever the result slot is free or draining
  // --------------------------------------------------------------------------
  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;

  // --------------------------------------------------------------------------
  // Speed clamp and per-wheel ramp
  // --------------------------------------------------------------------------
  assign max_s     = SPEED_WIDTH'(max_duty_q);
  assign arg_s     = cmd_i.speed_arg;
  assign s_clamped = (arg_s <= max_s) ? arg_s : max_s;

  ddsr_ramp #(.SPEED_WIDTH(SPEED_WIDTH)) u_ramp_left (
    .cur_i   (left_cur_q),
    .tgt_i   (left_tgt_q),
    .decel_i (decel_q),
    .next_o  (left_ramp)
  );

  ddsr_ramp #(.SPEED_WIDTH(SPEED_WIDTH)) u_ramp_right (
    .cur_i   (right_cur_q),
    .tgt_i   (right_tgt_q),
    .decel_i (decel_q),
    .next_o  (right_ramp)
  );

  // --------------------------------------------------------------------------
  // Command decode / next state
  // --------------------------------------------------------------------------
  always_comb begin
    left_cur_d  = left_cur_q;
    right_cur_d = right_cur_q;
    left_tgt_d  = left_tgt_q;
    right_tgt_d = right_tgt_q;
    fwd_d       = fwd_q;
    rev_d       = rev_q;
    turn_r_d    = turn_r_q;
    turn_l_d    = turn_l_q;
    cmp_d       = cmp_q;

    unique case (cmd_i.opcode)
      ddsr_pkg::OP_FORWARD: begin
        left_tgt_d  = s_clamped;
        right_tgt_d = s_clamped;
        fwd_d       = 1'b1;
        rev_d       = 1'b0;
        turn_r_d    = 1'b0;
        turn_l_d    = 1'b0;
      end
      ddsr_pkg::OP_REVERSE: begin
        left_tgt_d  = s_clamped;
        right_tgt_d = s_clamped;
        fwd_d       = 1'b0;
        rev_d       = 1'b1;
        turn_r_d    = 1'b0;
        turn_l_d    = 1'b0;
      end
      ddsr_pkg::OP_TURN_RIGHT: begin
        // inner (right) wheel at half speed; reverse flag untouched
        left_tgt_d  = s_clamped;
        right_tgt_d = s_clamped >> 1;
        turn_r_d    = 1'b1;
        turn_l_d    = 1'b0;
        fwd_d       = 1'b1;
      end
      ddsr_pkg::OP_TURN_LEFT: begin
        left_tgt_d  = s_clamped >> 1;
        right_tgt_d = s_clamped;
        turn_l_d    = 1'b1;
        turn_r_d    = 1'b0;
        fwd_d       = 1'b1;
      end
      ddsr_pkg::OP_STOP: begin
        left_tgt_d  = '0;
        right_tgt_d = '0;
        turn_r_d    = 1'b0;
        turn_l_d    = 1'b0;
      end
      ddsr_pkg::OP_SET_LEFT: begin
        left_tgt_d = s_clamped;
      end
      ddsr_pkg::OP_SET_RIGHT: begin
        right_tgt_d = s_clamped;
      end
      ddsr_pkg::OP_TICK: begin
        left_cur_d  = left_ramp;
        right_cur_d = right_ramp;
        // route to forward channels, else reverse, else hold all four
        if (fwd_q || turn_l_q || turn_r_q) begin
          cmp_d[1] = left_ramp;
          cmp_d[2] = right_ramp;
        end else if (rev_q) begin
          cmp_d[0] = left_ramp;
          cmp_d[3] = right_ramp;
        end
        // fully at rest: drop the direction modes
        if (left_ramp == '0 && right_ramp == '0 &&
            left_tgt_q == '0 && right_tgt_q == '0) begin
          fwd_d = 1'b0;
          rev_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign stopped_d = (left_cur_d == '0) && (right_cur_d == '0) &&
                     (left_tgt_d == '0) && (right_tgt_d == '0);

  // --------------------------------------------------------------------------
  // State registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_cur_q  <= '0;
      right_cur_q <= '0;
      left_tgt_q  <= '0;
      right_tgt_q <= '0;
      fwd_q       <= 1'b0;
      rev_q       <= 1'b0;
      turn_r_q    <= 1'b0;
      turn_l_q    <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        cmp_q[i] <= '0;
      end
    end else if (cmd_fire) begin
      left_cur_q  <= left_cur_d;
      right_cur_q <= right_cur_d;
      left_tgt_q  <= left_tgt_d;
      right_tgt_q <= right_tgt_d;
      fwd_q       <= fwd_d;
      rev_q       <= rev_d;
      turn_r_q    <= turn_r_d;
      turn_l_q    <= turn_l_d;
      cmp_q       <= cmp_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_fire) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      stopped_q <= stopped_d;
    end
  end

  // compare values and speeds come straight from state, which only moves
  // together with the result register
  assign res_o.valid             = res_valid_q;
  assign res_o.ch1_left_reverse  = cmp_q[0];
  assign res_o.ch2_left_forward  = cmp_q[1];
  assign res_o.ch3_right_forward = cmp_q[2];
  assign res_o.ch4_right_reverse = cmp_q[3];
  assign res_o.left_speed        = left_cur_q;
  assign res_o.right_speed       = right_cur_q;
  assign res_o.stopped           = stopped_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_fire |=> res_valid_q)
    else $error("accepted command produced no result");

  a_stop_clears_targets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_fire && cmd_i.opcode == ddsr_pkg::OP_STOP |=>
      left_tgt_q == '0 && right_tgt_q == '0)
    else $error("stop left a nonzero target");

  a_speed_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_fire && cmd_i.opcode != ddsr_pkg::OP_TICK |=>
      $stable(left_cur_q) && $stable(right_cur_q))
    else $error("current speed moved on a non-tick command");

  a_stopped_means_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && stopped_q |-> left_cur_q == '0 && right_cur_q == '0)
    else $error("stopped flag set with a wheel still moving");

endmodule : diff_drive_speed_ramp

`default_nettype wire
